// File: rtl/amav_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Acceleration magnitude averaging package
// Shared widths, register indexes, reset values and interface structs.
// ----------------------------------------------------------------------------
package amav_pkg;

    // Field and datapath widths.
    localparam int AXIS_W    = 16;  // one signed Q8.8 axis sample
    localparam int CFG_W     = 15;  // configuration register width
    localparam int CFG_IDX_W = 2;   // configuration register index width
    localparam int SQ_W      = 32;  // squared magnitude, unsigned Q16.16
    localparam int MAG_W     = 16;  // magnitude, unsigned Q8.8
    localparam int RD_W      = 18;  // one window reading, signed
    localparam int SUM_W     = 24;  // running sum, signed
    localparam int ABS_W     = 23;  // magnitude of the running sum
    localparam int MEAN_W    = 17;  // average output, signed Q8.8

    // Depth of the queue between front and back.
    localparam int FIFO_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH  = 2'd1;

    // Reset values: 9.81 and 0.2 in Q8.8.
    localparam logic [CFG_W-1:0] GRAVITY_RST = 15'd2511;
    localparam logic [CFG_W-1:0] THRESH_RST  = 15'd51;

    // One squared magnitude travelling through the queue.
    typedef struct packed {
        logic            valid;
        logic [SQ_W-1:0] sq;
    } t_sq_word;

    // Configuration seen by the back end.
    typedef struct packed {
        logic [CFG_W-1:0] gravity;
        logic [CFG_W-1:0] thresh;
    } t_cfg;

endpackage

// File: rtl/amav_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end: sample intake and squared magnitude
// Accepts one three-axis word and sums the three squares with one shared
// multiplier, then hands the squared magnitude to the queue.
// ----------------------------------------------------------------------------
module amav_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [amav_pkg::AXIS_W-1:0] i_accel_x,
    input  logic signed [amav_pkg::AXIS_W-1:0] i_accel_y,
    input  logic signed [amav_pkg::AXIS_W-1:0] i_accel_z,
    output amav_pkg::t_sq_word                o_push,
    input  logic                              i_full
);
    import amav_pkg::*;

    // Step counter: three products, three accumulations, then the push.
    localparam logic [2:0] STEP_PUSH = 3'd4;
    localparam logic [2:0] STEP_LAST_MUL = 3'd2;

    logic                     r_busy;
    logic [2:0]               r_step;
    logic signed [AXIS_W-1:0] r_x;
    logic signed [AXIS_W-1:0] r_y;
    logic signed [AXIS_W-1:0] r_z;
    logic [SQ_W-2:0]          r_prod;
    logic [SQ_W-1:0]          r_acc;

    logic signed [AXIS_W-1:0] w_axis;
    logic signed [SQ_W-1:0]   w_square;
    logic                     w_accept;
    logic                     w_pushed;

    assign o_in_stall = r_busy;
    assign w_accept   = i_in_valid && !r_busy;

    assign o_push.valid = r_busy && (r_step == STEP_PUSH);
    assign o_push.sq    = r_acc;
    assign w_pushed     = o_push.valid && !i_full;

    // Pick the axis for the current step.
    always_comb begin
        case (r_step[1:0])
            2'd0:    w_axis = r_x;
            2'd1:    w_axis = r_y;
            default: w_axis = r_z;
        endcase
    end

    assign w_square = w_axis * w_axis;

    // Control: idle until a word arrives, busy until it is pushed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (w_pushed) begin
            r_busy <= 1'b0;
        end else if (r_busy && (r_step != STEP_PUSH)) begin
            r_step <= r_step + 3'd1;
        end
    end

    // Datapath: square one axis per cycle, add the previous square.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x   <= i_accel_x;
            r_y   <= i_accel_y;
            r_z   <= i_accel_z;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_step <= STEP_LAST_MUL) begin
                r_prod <= w_square[SQ_W-2:0];
            end
            if ((r_step != 3'd0) && (r_step != STEP_PUSH)) begin
                r_acc <= r_acc + SQ_W'(r_prod);
            end
        end
    end

endmodule

// File: rtl/amav_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Squared magnitude queue
// A short first-in first-out buffer that decouples front and back end.
// ----------------------------------------------------------------------------
module amav_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  amav_pkg::t_sq_word i_push,
    output logic               o_full,
    output amav_pkg::t_sq_word o_head,
    input  logic               i_pop
);
    import amav_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [SQ_W-1:0]  r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic w_wr;
    logic w_rd;

    assign o_full       = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.sq    = r_mem[r_rd_ptr];

    assign w_wr = i_push.valid && !o_full;
    assign w_rd = i_pop && o_head.valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push.sq;
        end
    end

endmodule

// File: rtl/amav_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Back end: square root, moving window and average
// Takes squared magnitudes from the queue, finds the integer square root
// one result bit per cycle, updates the ring window and running sum, and
// divides by the window length through a reciprocal multiply.
// ----------------------------------------------------------------------------
module amav_back #(
    parameter int WINDOW_LEN = 30
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  amav_pkg::t_sq_word                  i_head,
    output logic                                o_pop,
    input  amav_pkg::t_cfg                      i_cfg,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [amav_pkg::MEAN_W-1:0]  o_mean_accel,
    output logic                                o_apogee
);
    import amav_pkg::*;

    localparam int POS_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int DIV_SHIFT = SUM_W;
    localparam int PROD_W    = ABS_W + SUM_W;
    // Reciprocal of the window length, rounded down; corrected afterwards.
    localparam logic [SUM_W-1:0] RECIP = SUM_W'((64'd1 << DIV_SHIFT) / WINDOW_LEN);
    localparam logic [ABS_W-1:0] WLEN_C = ABS_W'(WINDOW_LEN);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQRT = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_ABS  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_FIX  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    localparam logic [3:0] SQRT_LAST = 4'd15;

    logic [2:0]              r_state;
    logic [3:0]              r_iter;
    logic [SQ_W-1:0]         r_rem;
    logic [SQ_W-1:0]         r_root;
    logic [SQ_W-1:0]         r_bit;
    logic [POS_W-1:0]        r_pos;
    logic [WINDOW_LEN-1:0]   r_vld;
    logic signed [RD_W-1:0]  r_win [WINDOW_LEN];
    logic signed [RD_W-1:0]  r_rd_data;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_neg;
    logic [ABS_W-1:0]        r_abs;
    logic [ABS_W-1:0]        r_q;
    logic                    r_out_valid;
    logic [MEAN_W-1:0]       r_mean;
    logic                    r_apogee;

    logic [SQ_W-1:0]         w_trial;
    logic signed [RD_W-1:0]  w_reading;
    logic signed [RD_W-1:0]  w_old;
    logic signed [SUM_W-1:0] n_sum;
    logic [SUM_W-1:0]        w_neg_sum;
    logic [PROD_W-1:0]       w_prod;
    logic [ABS_W-1:0]        w_back;
    logic [ABS_W-1:0]        w_rest;
    logic [ABS_W-1:0]        n_q;
    logic [MEAN_W-1:0]       w_q_lo;
    logic                    w_out_free;
    logic                    n_out_valid;

    assign o_pop        = (r_state == ST_IDLE) && i_head.valid;
    assign o_out_valid  = r_out_valid;
    assign o_mean_accel = r_mean;
    assign o_apogee     = r_apogee;
    assign w_out_free   = !r_out_valid || !i_out_stall;

    // The output word is loaded in the output step and held while stalled.
    assign n_out_valid  = ((r_state == ST_OUT) && w_out_free) ||
                          (r_out_valid && i_out_stall);

    // Square root step: try the current bit pair against the remainder.
    assign w_trial = r_root + r_bit;

    // Window update: new reading, the reading it replaces, new sum.
    assign w_reading = $signed({2'b00, r_root[MAG_W-1:0]}) - $signed({3'b000, i_cfg.gravity});
    assign w_old     = r_vld[r_pos] ? r_rd_data : '0;
    assign n_sum     = r_sum - SUM_W'(w_old) + SUM_W'(w_reading);
    assign w_neg_sum = SUM_W'(0) - r_sum;

    // Division: the reciprocal quotient is exact or one short.
    assign w_prod = PROD_W'(r_abs) * PROD_W'(RECIP);
    assign w_back = r_q * WLEN_C;
    assign w_rest = r_abs - w_back;
    assign n_q    = (w_rest >= WLEN_C) ? r_q + 1'b1 : r_q;
    assign w_q_lo = r_q[MEAN_W-1:0];

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_iter      <= '0;
            r_pos       <= '0;
            r_vld       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                ST_IDLE: begin
                    if (i_head.valid) begin
                        r_rem   <= i_head.sq;
                        r_root  <= '0;
                        r_bit   <= SQ_W'(1) << (SQ_W - 2);
                        r_iter  <= '0;
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (r_rem >= w_trial) begin
                        r_rem  <= r_rem - w_trial;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit  <= r_bit >> 2;
                    r_iter <= r_iter + 4'd1;
                    if (r_iter == SQRT_LAST) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    r_sum        <= n_sum;
                    r_vld[r_pos] <= 1'b1;
                    r_pos        <= (r_pos == POS_W'(WINDOW_LEN - 1)) ? '0 : r_pos + 1'b1;
                    r_state      <= ST_ABS;
                end
                ST_ABS: begin
                    r_neg   <= r_sum[SUM_W-1];
                    r_abs   <= r_sum[SUM_W-1] ? w_neg_sum[ABS_W-1:0] : r_sum[ABS_W-1:0];
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_q     <= w_prod[PROD_W-1:DIV_SHIFT];
                    r_state <= ST_FIX;
                end
                ST_FIX: begin
                    r_q     <= n_q;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_mean      <= r_neg ? MEAN_W'(0) - w_q_lo : w_q_lo;
                        r_apogee    <= (r_q < ABS_W'(i_cfg.thresh));
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Window memory with registered read at the write position.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_win[r_pos];
        if (r_state == ST_UPD) begin
            r_win[r_pos] <= w_reading;
        end
    end

endmodule

// File: rtl/accel_magnitude_moving_average_apogee_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Acceleration magnitude moving average with apogee flag
// Magnitude of a three-axis sample less gravity, averaged over a window.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one word of three signed Q8.8 axis samples with
// i_in_valid / o_in_stall; the output channel carries one word per input,
// the signed Q8.8 window average and the apogee flag, with o_out_valid /
// i_out_stall. Gravity offset (index 0) and zero threshold (index 1) are
// written through i_cfg_we; the user must write them only while no word is
// in flight, as the block does not enforce this. The front end sums the
// three squares with one multiplier and pushes the sum before it takes the
// next word. The back end pops a word, then runs the bit-serial square
// root, window update, absolute value, reciprocal multiply, quotient
// correction and output; the back end sets the sustained rate.
// A two-entry queue between the ends lets new words enter while the back
// end works or a result waits. When the receiver stalls, the result is
// held and the back end waits in its output step; the queue then fills
// and o_in_stall rises. Reset clears the window (per-entry valid bits),
// the running sum, the queue and the output, and restores default
// registers.
// ----------------------------------------------------------------------------
module accel_magnitude_moving_average_apogee_top #(
    parameter int WINDOW_LEN = 30
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [amav_pkg::AXIS_W-1:0]   i_accel_x,
    input  logic signed [amav_pkg::AXIS_W-1:0]   i_accel_y,
    input  logic signed [amav_pkg::AXIS_W-1:0]   i_accel_z,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [amav_pkg::MEAN_W-1:0]   o_mean_accel,
    output logic                                 o_apogee,
    input  logic                                 i_cfg_we,
    input  logic [amav_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [amav_pkg::CFG_W-1:0]           i_cfg_wdata
);
    import amav_pkg::*;

    logic [CFG_W-1:0] r_gravity;
    logic [CFG_W-1:0] r_thresh;
    t_cfg             w_cfg;
    t_sq_word         w_push;
    t_sq_word         w_head;
    logic             w_full;
    logic             w_pop;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= GRAVITY_RST;
            r_thresh  <= THRESH_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_GRAVITY) begin
                r_gravity <= i_cfg_wdata;
            end else if (i_cfg_index == CFG_THRESH) begin
                r_thresh <= i_cfg_wdata;
            end
        end
    end

    assign w_cfg.gravity = r_gravity;
    assign w_cfg.thresh  = r_thresh;

    amav_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_accel_x  (i_accel_x),
        .i_accel_y  (i_accel_y),
        .i_accel_z  (i_accel_z),
        .o_push     (w_push),
        .i_full     (w_full)
    );

    amav_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    amav_back #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .i_cfg        (w_cfg),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_mean_accel (o_mean_accel),
        .o_apogee     (o_apogee)
    );

endmodule

// File: tb/amav_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Acceleration magnitude averaging result checker
// Watches the sample and result channels and the register port, keeps its
// own copy of the reading window, running sum and registers, predicts the
// window average and apogee flag for every accepted sample, and compares
// each accepted result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module amav_result_checker #(
    parameter int WINDOW_LEN = 30
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic signed [amav_pkg::AXIS_W-1:0]   i_accel_x,
    input  logic signed [amav_pkg::AXIS_W-1:0]   i_accel_y,
    input  logic signed [amav_pkg::AXIS_W-1:0]   i_accel_z,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic signed [amav_pkg::MEAN_W-1:0]   i_mean_accel,
    input  logic                                 i_apogee,
    input  logic                                 i_cfg_we,
    input  logic [amav_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [amav_pkg::CFG_W-1:0]           i_cfg_wdata,
    output int                                   o_mismatches,
    output int                                   o_pending,
    output int                                   o_checked,
    output int                                   o_flagged
);
    import amav_pkg::*;

    // One predicted result word.
    typedef struct {
        logic signed [MEAN_W-1:0] mean;
        logic                     apogee;
    } avg_word_t;

    // Shadow copy of the block's state and registers.
    logic signed [RD_W-1:0]  readings [WINDOW_LEN];
    int unsigned             slot;
    logic signed [SUM_W-1:0] run_sum;
    logic [CFG_W-1:0]        gravity;
    logic [CFG_W-1:0]        thresh;

    // Averages predicted but not yet seen on the result channel.
    avg_word_t awaited_avg [$];

    int mismatches = 0;
    int checked    = 0;
    int flagged    = 0;

    assign o_mismatches = mismatches;
    assign o_pending    = awaited_avg.size();
    assign o_checked    = checked;
    assign o_flagged    = flagged;

    // Print one line per problem and count it.
    task automatic report(input string what);
        mismatches++;
        $display("[%0t] checker: %s", $time, what);
    endtask

    // Floor of the square root, one result bit per pair of input bits.
    function automatic logic [MAG_W-1:0] floor_sqrt(input logic [SQ_W-1:0] v);
        logic [SQ_W-1:0] root;
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] bitv;
        root = '0;
        rem  = v;
        bitv = 32'h4000_0000;
        while (bitv > rem) begin
            bitv = bitv >> 2;
        end
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root[MAG_W-1:0];
    endfunction

    // Fold one sample into the window and return the new average word.
    function automatic avg_word_t window_average(
        input logic signed [AXIS_W-1:0] ax,
        input logic signed [AXIS_W-1:0] ay,
        input logic signed [AXIS_W-1:0] az
    );
        int              sx;
        int              sy;
        int              sz;
        logic [SQ_W-1:0] sq;
        int              mag;
        int              rd;
        int              avg;
        int              absavg;
        avg_word_t       w;
        sx  = ax;
        sy  = ay;
        sz  = az;
        sq  = $unsigned(sx * sx) + $unsigned(sy * sy) + $unsigned(sz * sz);
        mag = int'(floor_sqrt(sq));
        rd  = mag - int'(gravity);
        if (slot >= WINDOW_LEN) begin
            slot = 0;
        end
        // Drop the reading being overwritten and add the new one.
        run_sum = SUM_W'(int'(run_sum) - int'(readings[slot]) + rd);
        readings[slot] = RD_W'(rd);
        slot = (slot + 1 >= WINDOW_LEN) ? 0 : slot + 1;
        // Signed division truncates toward zero.
        avg    = int'(run_sum) / WINDOW_LEN;
        absavg = (avg < 0) ? -avg : avg;
        w.mean   = MEAN_W'(avg);
        w.apogee = (absavg < int'(thresh));
        return w;
    endfunction

    // Track registers, predict on each accepted sample, check each result.
    always @(posedge i_clk) begin
        avg_word_t want;
        if (!i_rst_n) begin
            foreach (readings[k]) begin
                readings[k] = '0;
            end
            slot    = 0;
            run_sum = '0;
            gravity = GRAVITY_RST;
            thresh  = THRESH_RST;
            awaited_avg.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GRAVITY: begin
                        gravity = i_cfg_wdata;
                    end
                    CFG_THRESH: begin
                        thresh = i_cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_avg.push_back(window_average(i_accel_x, i_accel_y, i_accel_z));
            end
            if (i_out_valid && !i_out_stall) begin
                if (awaited_avg.size() == 0) begin
                    report($sformatf("result word with no sample waiting: mean %0d apogee %0b",
                                     i_mean_accel, i_apogee));
                end else begin
                    want = awaited_avg.pop_front();
                    checked++;
                    if (i_apogee) begin
                        flagged++;
                    end
                    if (i_mean_accel !== want.mean) begin
                        report($sformatf("result %0d: mean_accel %0d, predicted %0d",
                                         checked, i_mean_accel, want.mean));
                    end
                    if (i_apogee !== want.apogee) begin
                        report($sformatf("result %0d: apogee %0b, predicted %0b",
                                         checked, i_apogee, want.apogee));
                    end
                end
            end
        end
    end

endmodule

// File: tb/accel_magnitude_moving_average_apogee_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Acceleration magnitude moving average testbench
// Drives directed and random three-axis samples through the block in bursts
// while the receiver stalls on its own pattern, reprograms gravity offset and
// zero threshold between phases, and leaves all checking to the result
// checker, whose failure count decides the verdict.
// ----------------------------------------------------------------------------
module accel_magnitude_moving_average_apogee_top_tb;
    import amav_pkg::*;

    localparam int WIN_LEN         = 30;
    localparam int PHASES          = 7;
    localparam int WORDS_PER_PHASE = 112;
    localparam int SETTLE_CYCLES   = 40;
    localparam int TAIL_CYCLES     = 80;
    localparam int IDLE_LIMIT      = 5000;

    // Register indexes that the block does not implement.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic signed [AXIS_W-1:0] i_accel_x;
    logic signed [AXIS_W-1:0] i_accel_y;
    logic signed [AXIS_W-1:0] i_accel_z;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [MEAN_W-1:0] o_mean_accel;
    logic                     o_apogee;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_W-1:0]         i_cfg_wdata;

    int mismatches;
    int pending;
    int checked;
    int flagged;

    int               burst_left  = 0;
    int               words_sent  = 0;
    int               settings    = 0;
    int               idle_cycles = 0;
    int               stall_mode  = 0;
    int               stall_left  = 0;
    int               stall_phase = 0;
    logic [CFG_W-1:0] cur_gravity = GRAVITY_RST;

    accel_magnitude_moving_average_apogee_top #(
        .WINDOW_LEN (WIN_LEN)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_accel_x    (i_accel_x),
        .i_accel_y    (i_accel_y),
        .i_accel_z    (i_accel_z),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_mean_accel (o_mean_accel),
        .o_apogee     (o_apogee),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    amav_result_checker #(
        .WINDOW_LEN (WIN_LEN)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_accel_x    (i_accel_x),
        .i_accel_y    (i_accel_y),
        .i_accel_z    (i_accel_z),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_mean_accel (o_mean_accel),
        .i_apogee     (o_apogee),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_flagged    (flagged)
    );

    // Clock with a 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver stall: stretches of none, light, heavy and periodic stalling.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        stall_phase = (stall_phase + 1) % 7;
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 9) < 3);
            2:       i_out_stall <= ($urandom_range(0, 9) < 8);
            default: i_out_stall <= (stall_phase < 3);
        endcase
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timed out after %0d cycles without a word moving", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic signed [AXIS_W-1:0] clip_axis(input int v);
        if (v > 32767) begin
            return 16'sh7fff;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return AXIS_W'(v);
    endfunction

    // Offer one sample word and hold it until accepted; gaps open between bursts.
    task automatic push_sample(input logic signed [AXIS_W-1:0] ax,
                               input logic signed [AXIS_W-1:0] ay,
                               input logic signed [AXIS_W-1:0] az);
        int   gap;
        logic stalled;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_accel_x  <= ax;
        i_accel_y  <= ay;
        i_accel_z  <= az;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
        words_sent++;
    endtask

    // Many samples near the gravity vector so the average hovers near zero.
    task automatic make_sample(output logic signed [AXIS_W-1:0] ax,
                               output logic signed [AXIS_W-1:0] ay,
                               output logic signed [AXIS_W-1:0] az);
        int v [3];
        int kind;
        int axis;
        int lead;
        int picks [5];
        picks = '{-32768, 32767, 0, -1, 1};
        kind  = $urandom_range(0, 9);
        if (kind <= 5) begin
            axis = $urandom_range(0, 2);
            if ($urandom_range(0, 4) == 0) begin
                // Free fall: all axes near zero.
                lead = $urandom_range(0, 200) - 100;
            end else begin
                lead = int'(cur_gravity) + $urandom_range(0, 200) - 100;
            end
            if ($urandom_range(0, 1) == 1) begin
                lead = -lead;
            end
            foreach (v[k]) begin
                v[k] = (k == axis) ? lead : $urandom_range(0, 120) - 60;
            end
        end else if (kind <= 7) begin
            foreach (v[k]) begin
                v[k] = int'($signed(16'($urandom())));
            end
        end else if (kind == 8) begin
            foreach (v[k]) begin
                v[k] = picks[$urandom_range(0, 4)];
            end
        end else begin
            axis = $urandom_range(0, 2);
            foreach (v[k]) begin
                v[k] = (k == axis) ? int'($signed(16'($urandom()))) : 0;
            end
        end
        ax = clip_axis(v[0]);
        ay = clip_axis(v[1]);
        az = clip_axis(v[2]);
    endtask

    // Wait until every result has come back, then let the block go quiet.
    task automatic drain(input int extra);
        i_in_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    // Present one register write; the caller lowers the write enable after the last.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        if (idx == CFG_GRAVITY) begin
            cur_gravity = val;
        end
        @(posedge i_clk);
    endtask

    initial begin
        logic signed [AXIS_W-1:0] sx;
        logic signed [AXIS_W-1:0] sy;
        logic signed [AXIS_W-1:0] sz;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_accel_x   <= '0;
        i_accel_y   <= '0;
        i_accel_z   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_GRAVITY;
        i_cfg_wdata <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words under reset registers; the window still holds zeros.
        push_sample(16'sd0, 16'sd0, 16'sd0);
        push_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
        push_sample(16'sh8000, 16'sh8000, 16'sh8000);
        push_sample(16'sh8000, 16'sd0, 16'sd0);
        push_sample(16'sd0, 16'sh8000, 16'sd0);
        push_sample(16'sd0, 16'sd0, 16'sh7fff);
        push_sample(16'sd2511, 16'sd0, 16'sd0);
        push_sample(16'sd0, 16'sd0, -16'sd2511);
        push_sample(16'sd1, 16'sd1, 16'sd1);
        push_sample(-16'sd1, -16'sd1, -16'sd1);
        push_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
        push_sample(16'sh5555, 16'shaaaa, 16'sh5555);
        push_sample(16'shaaaa, 16'sh5555, 16'shaaaa);
        push_sample(16'sd256, 16'sd0, 16'sd0);
        push_sample(16'sd2500, 16'sd100, -16'sd50);
        push_sample(16'sd0, 16'sd2562, 16'sd0);
        settings++;

        for (int phase = 0; phase < PHASES; phase++) begin
            drain(SETTLE_CYCLES);
            case (phase)
                0: begin
                    write_reg(CFG_GRAVITY, '0);
                    write_reg(CFG_THRESH, '0);
                end
                1: begin
                    write_reg(CFG_GRAVITY, '1);
                    write_reg(CFG_THRESH, '1);
                end
                2: begin
                    // Writes to unused indexes must leave both registers alone.
                    write_reg(CFG_GRAVITY, GRAVITY_RST);
                    write_reg(CFG_THRESH, 15'($urandom_range(20, 400)));
                    write_reg(CFG_SPARE_2, 15'($urandom()));
                    write_reg(CFG_SPARE_3, 15'($urandom()));
                end
                default: begin
                    if ($urandom_range(0, 2) == 0) begin
                        write_reg(CFG_GRAVITY, 15'($urandom()));
                    end else begin
                        write_reg(CFG_GRAVITY, 15'($urandom_range(2000, 3000)));
                    end
                    write_reg(CFG_THRESH, 15'($urandom_range(0, 600)));
                end
            endcase
            i_cfg_we <= 1'b0;
            settings++;
            repeat (WORDS_PER_PHASE) begin
                make_sample(sx, sy, sz);
                push_sample(sx, sy, sz);
            end
        end

        drain(TAIL_CYCLES);
        $display("Sent %0d sample words under %0d register settings.", words_sent, settings);
        $display("Checked %0d average words, %0d of them with the apogee flag set.",
                 checked, flagged);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/amav_pkg.sv
rtl/amav_front.sv
rtl/amav_fifo.sv
rtl/amav_back.sv
rtl/accel_magnitude_moving_average_apogee_top.sv
tb/amav_result_checker.sv
tb/accel_magnitude_moving_average_apogee_top_tb.sv
